// ===== rtl/tccs_pkg.sv =====
package tccs_pkg;

   // Default geometry of the text screen.
   localparam int unsigned DEFAULT_COLS = 80;
   localparam int unsigned DEFAULT_ROWS = 25;

   localparam int unsigned CELL_W = 16;

   localparam logic [15:0] BLANK_CELL  = 16'h0720;
   localparam logic [7:0]  BLANK_CHAR  = 8'h20;
   localparam logic [7:0]  ATTR_RESET  = 8'h07;
   localparam int unsigned TAB_STEP    = 8;

   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_READ
   } state_type;

   // Result word, packed from the highest bit down as it appears on the bus.
   typedef struct packed {
      logic [1:0]  pad;
      logic        scrolled;
      logic        wrote_cell;
      logic [15:0] cell_value;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
   } rsp_type;

endpackage

// ===== rtl/tccs_ram.sv =====
module tccs_ram #(
   parameter int unsigned WIDTH = tccs_pkg::CELL_W,
   parameter int unsigned DEPTH = tccs_pkg::DEFAULT_COLS * tccs_pkg::DEFAULT_ROWS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_console_cursor_scroll_unit.sv =====
// Text console engine with a cursor and a scrolling character store.
//
// Commands arrive on the req_ stream: tuser carries the opcode (put, clear,
// read), tdata the character byte and the cell index. Every command gives
// exactly one word on the rsp_ stream with the cursor after the command, the
// cell value and the wrote_cell and scrolled flags. The csr_ channel writes
// the attribute byte that is used for printed characters and scrolled-in
// blanks; it is always ready and should be written only while idle.
//
// The screen lives in one RAM of ROWS*COLS cells with rows addressed
// circularly, so a scroll only moves the top-row base and blanks one row.
// The result word is loaded into the output register from the execute step
// for a put that does not scroll, the unused opcode and a read past the end,
// from the read step after the RAM read for other reads, at the end of the row
// fill for a put that scrolls (one blank cell per cycle) and at the end of the
// screen fill for a clear. One command is processed at a time and the next is
// taken only once its result is loaded into the output register; a pending
// result does not block acceptance. After reset the RAM is swept to blanks with req_tready low.
// When the receiver stalls, the result word holds and the engine waits with
// its finished result until the output register is free.
module text_console_cursor_scroll_unit #(
   parameter int unsigned COLS = tccs_pkg::DEFAULT_COLS,
   parameter int unsigned ROWS = tccs_pkg::DEFAULT_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   // Command stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], cell_index[18:8], zero pad
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                    // cell_value[27:12], wrote_cell[28],
                                    // scrolled[29], zero pad
   // Attribute register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int unsigned CELL_COUNT = ROWS * COLS;
   localparam int unsigned AW = $clog2(CELL_COUNT);
   localparam int unsigned RW = $clog2(ROWS);
   localparam int unsigned CW = $clog2(COLS);
   // Width for the read index arithmetic: wide enough for the 11-bit index
   // and for a RAM address, plus a carry bit.
   localparam int unsigned SW = ((AW > 11) ? AW : 11) + 1;

   // Control state.
   tccs_pkg::state_type state_ff, state_in;
   logic [RW-1:0]       cur_row_ff, cur_row_in;
   logic [CW-1:0]       cur_col_ff, cur_col_in;
   logic [AW-1:0]       top_base_ff, top_base_in;   // physical address of logical row 0
   logic [AW-1:0]       fill_left_ff, fill_left_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]          attr_ff, attr_in;

   // Payload registers.
   tccs_pkg::op_type    op_ff, op_in;
   logic [7:0]          char_ff, char_in;
   logic [10:0]         idx_ff, idx_in;
   logic [AW-1:0]       fill_addr_ff, fill_addr_in;
   logic [15:0]         fill_value_ff, fill_value_in;
   tccs_pkg::rsp_type   res_ff, res_in;
   tccs_pkg::rsp_type   rsp_ff, rsp_in;

   // Memory port.
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [15:0]         mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [15:0]         mem_rd_data;

   // Command evaluation.
   logic                req_accept;
   logic                rsp_free;
   logic                exec_go;
   logic                rsp_load;
   tccs_pkg::rsp_type   rsp_next;
   tccs_pkg::rsp_type   exec_res;
   logic                is_print;
   logic                adv_row;
   logic                do_scroll;
   logic [CW-1:0]       new_col;
   logic [RW-1:0]       new_row;
   logic [CW:0]         col_inc;
   logic [CW:0]         col_tab;
   logic [15:0]         put_cell;
   logic [AW:0]         row_base;
   logic [AW:0]         put_sum;
   logic [AW-1:0]       put_addr;
   logic [SW-1:0]       idx_wide;
   logic [SW-1:0]       idx_sum;
   logic                idx_in_range;
   logic [AW-1:0]       read_addr;
   logic [AW:0]         top_next;
   logic [RW+4:0]       row_out;
   logic [CW+6:0]       col_out;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign exec_go    = (state_ff == tccs_pkg::ST_EXEC) && rsp_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ff;

   // Cursor arithmetic for a put, and the physical addresses of the put and
   // the read. The screen origin rotates by one row on every scroll, so a
   // logical position is offset by the top-row base and folded back once.
   always_comb begin
      col_inc  = (CW + 1)'(cur_col_ff) + (CW + 1)'(1);
      col_tab  = ((CW + 1)'(cur_col_ff) + (CW + 1)'(tccs_pkg::TAB_STEP))
                 & ~(CW + 1)'(tccs_pkg::TAB_STEP - 1);
      is_print = 1'b0;
      adv_row  = 1'b0;
      new_col  = cur_col_ff;
      case (char_ff)
         tccs_pkg::CHAR_LF: begin
            new_col = '0;
            adv_row = 1'b1;
         end
         tccs_pkg::CHAR_CR: begin
            new_col = '0;
         end
         tccs_pkg::CHAR_TAB: begin
            if (col_tab >= (CW + 1)'(COLS)) begin
               new_col = '0;
               adv_row = 1'b1;
            end else begin
               new_col = col_tab[CW-1:0];
            end
         end
         default: begin
            is_print = 1'b1;
            if (col_inc >= (CW + 1)'(COLS)) begin
               new_col = '0;
               adv_row = 1'b1;
            end else begin
               new_col = col_inc[CW-1:0];
            end
         end
      endcase

      // Advancing from the bottom row scrolls; the cursor stays on that row.
      do_scroll = adv_row && (cur_row_ff == RW'(ROWS - 1));
      if (adv_row && !do_scroll) begin
         new_row = cur_row_ff + RW'(1);
      end else begin
         new_row = cur_row_ff;
      end

      put_cell = {attr_ff, char_ff};
      row_base = (AW + 1)'(cur_row_ff) * (AW + 1)'(COLS);
      put_sum  = row_base + (AW + 1)'(cur_col_ff) + (AW + 1)'(top_base_ff);
      if (put_sum >= (AW + 1)'(CELL_COUNT)) begin
         put_sum = put_sum - (AW + 1)'(CELL_COUNT);
      end
      put_addr = put_sum[AW-1:0];

      idx_wide     = SW'(idx_ff);
      idx_in_range = idx_wide < SW'(CELL_COUNT);
      idx_sum      = idx_wide + SW'(top_base_ff);
      if (idx_sum >= SW'(CELL_COUNT)) begin
         idx_sum = idx_sum - SW'(CELL_COUNT);
      end
      read_addr = idx_sum[AW-1:0];

      top_next = (AW + 1)'(top_base_ff) + (AW + 1)'(COLS);
      if (top_next >= (AW + 1)'(CELL_COUNT)) begin
         top_next = '0;
      end

      // Result of the command as it stands after this step.
      exec_res = '0;
      case (op_ff)
         tccs_pkg::OP_PUT: begin
            row_out             = (RW + 5)'(new_row);
            col_out             = (CW + 7)'(new_col);
            exec_res.cell_value = is_print ? put_cell : 16'd0;
            exec_res.wrote_cell = is_print;
            exec_res.scrolled   = do_scroll;
         end
         tccs_pkg::OP_CLEAR: begin
            row_out = '0;
            col_out = '0;
         end
         default: begin
            row_out = (RW + 5)'(cur_row_ff);
            col_out = (CW + 7)'(cur_col_ff);
         end
      endcase
      exec_res.cursor_row = row_out[4:0];
      exec_res.cursor_col = col_out[6:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tccs_pkg::ST_INIT: begin
            if (fill_left_ff == '0) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         tccs_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = tccs_pkg::ST_EXEC;
            end
         end
         tccs_pkg::ST_EXEC: begin
            if (rsp_free) begin
               case (op_ff)
                  tccs_pkg::OP_PUT: begin
                     state_in = do_scroll ? tccs_pkg::ST_FILL : tccs_pkg::ST_IDLE;
                  end
                  tccs_pkg::OP_CLEAR: begin
                     state_in = tccs_pkg::ST_FILL;
                  end
                  tccs_pkg::OP_READ: begin
                     state_in = idx_in_range ? tccs_pkg::ST_READ : tccs_pkg::ST_IDLE;
                  end
                  default: begin
                     state_in = tccs_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         tccs_pkg::ST_FILL: begin
            if ((fill_left_ff == '0) && rsp_free) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         tccs_pkg::ST_READ: begin
            if (rsp_free) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccs_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: handshake, memory port and the result load.
   always_comb begin
      req_tready  = (state_ff == tccs_pkg::ST_IDLE);
      mem_wr_en   = 1'b0;
      mem_wr_addr = fill_addr_ff;
      mem_wr_data = fill_value_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = read_addr;
      rsp_load    = 1'b0;
      rsp_next    = exec_res;
      case (state_ff)
         tccs_pkg::ST_INIT: begin
            mem_wr_en = 1'b1;
         end
         tccs_pkg::ST_EXEC: begin
            if (exec_go) begin
               case (op_ff)
                  tccs_pkg::OP_PUT: begin
                     mem_wr_en   = is_print;
                     mem_wr_addr = put_addr;
                     mem_wr_data = put_cell;
                     rsp_load    = !do_scroll;
                  end
                  tccs_pkg::OP_CLEAR: begin
                     rsp_load = 1'b0;
                  end
                  tccs_pkg::OP_READ: begin
                     mem_rd_en = idx_in_range;
                     rsp_load  = !idx_in_range;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         tccs_pkg::ST_FILL: begin
            // The last cell is rewritten while the result register is busy.
            mem_wr_en = 1'b1;
            rsp_next  = res_ff;
            rsp_load  = (fill_left_ff == '0) && rsp_free;
         end
         tccs_pkg::ST_READ: begin
            rsp_next            = res_ff;
            rsp_next.cell_value = mem_rd_data;
            rsp_load            = rsp_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      top_base_in   = top_base_ff;
      fill_left_in  = fill_left_ff;
      fill_addr_in  = fill_addr_ff;
      fill_value_in = fill_value_ff;
      attr_in       = csr_valid ? csr_data : attr_ff;
      op_in         = op_ff;
      char_in       = char_ff;
      idx_in        = idx_ff;
      res_in        = res_ff;
      rsp_in        = rsp_load ? rsp_next : rsp_ff;
      rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);

      if (req_accept) begin
         op_in   = tccs_pkg::op_type'(req_tuser[1:0]);
         char_in = req_tdata[7:0];
         idx_in  = req_tdata[18:8];
      end

      if (exec_go) begin
         res_in = exec_res;
         case (op_ff)
            tccs_pkg::OP_PUT: begin
               cur_row_in = new_row;
               cur_col_in = new_col;
               if (do_scroll) begin
                  // The old top row becomes the new bottom row and is blanked.
                  top_base_in   = top_next[AW-1:0];
                  fill_addr_in  = top_base_ff;
                  fill_left_in  = AW'(COLS - 1);
                  fill_value_in = {attr_ff, tccs_pkg::BLANK_CHAR};
               end
            end
            tccs_pkg::OP_CLEAR: begin
               cur_row_in    = '0;
               cur_col_in    = '0;
               top_base_in   = '0;
               fill_addr_in  = '0;
               fill_left_in  = AW'(CELL_COUNT - 1);
               fill_value_in = tccs_pkg::BLANK_CELL;
            end
            default: begin
               cur_row_in = cur_row_ff;
            end
         endcase
      end

      if (((state_ff == tccs_pkg::ST_FILL) || (state_ff == tccs_pkg::ST_INIT))
          && (fill_left_ff != '0)) begin
         fill_left_in = fill_left_ff - AW'(1);
         fill_addr_in = fill_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tccs_pkg::ST_INIT;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         top_base_ff   <= '0;
         fill_left_ff  <= AW'(CELL_COUNT - 1);
         fill_addr_ff  <= '0;
         fill_value_ff <= tccs_pkg::BLANK_CELL;
         rsp_tvalid_ff <= 1'b0;
         attr_ff       <= tccs_pkg::ATTR_RESET;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         top_base_ff   <= top_base_in;
         fill_left_ff  <= fill_left_in;
         fill_addr_ff  <= fill_addr_in;
         fill_value_ff <= fill_value_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         attr_ff       <= attr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      char_ff <= char_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   tccs_ram #(
      .WIDTH (tccs_pkg::CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The cursor and the rotating origin always stay on the screen.
   assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff < RW'(ROWS)) && ((CW + 1)'(cur_col_ff) < (CW + 1)'(COLS))
      && ((AW + 1)'(top_base_ff) < (AW + 1)'(CELL_COUNT)))
      else $error("cursor or screen origin out of range");

   // Every RAM write lands inside the screen.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((AW + 1)'(mem_wr_addr) < (AW + 1)'(CELL_COUNT)))
      else $error("RAM write beyond the screen");

   // A loaded result always ends the command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == tccs_pkg::ST_IDLE))
      else $error("result loaded while the command is still running");

   // An accepted command enters the execute state in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == tccs_pkg::ST_EXEC))
      else $error("accepted command not evaluated");

   // A scroll always starts a row fill.
   assert property (@(posedge clock) disable iff (reset)
      (exec_go && (op_ff == tccs_pkg::OP_PUT) && do_scroll)
      |=> ((state_ff == tccs_pkg::ST_FILL) && (fill_left_ff == AW'(COLS - 1))))
      else $error("scroll without a row fill");

endmodule

// ===== sim/text_console_cursor_scroll_unit_tb.sv =====
module text_console_cursor_scroll_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Screen geometry of the instance under test; the block runs at its defaults.
   localparam int unsigned COLS       = tccs_pkg::DEFAULT_COLS;
   localparam int unsigned ROWS       = tccs_pkg::DEFAULT_ROWS;
   localparam int unsigned CELL_COUNT = COLS * ROWS;

   // The limit is set well above the slowest correct run: about 775 commands, a
   // handful of full-screen clears, a few hundred scrolls, plus the sweep after
   // reset and the idle and stall time on both streams.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   // Number of random commands in each attribute phase.
   localparam int unsigned PHASE_ITEMS = 150;

   // One command as it travels on the request stream.
   typedef struct {
      tccs_pkg::op_type op;
      logic [7:0]       ch;
      logic [10:0]      idx;
   } console_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // char_code[7:0], cell_index[18:8], zero pad
   logic [1:0]  req_tuser  = tccs_pkg::OP_NONE;   // opcode[1:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;          // cursor_row[4:0], cursor_col[11:5],
                                    // cell_value[27:12], wrote_cell[28],
                                    // scrolled[29], zero pad

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data  = '0;

   // Commands waiting to be driven, and the result words that the block owes us.
   console_cmd_type   command_backlog[$];
   tccs_pkg::rsp_type owed_replies[$];

   // Our own image of the console: the character store, the cursor and the
   // attribute register.
   logic [15:0] screen_image[CELL_COUNT];
   int unsigned cursor_row_now = 0;
   int unsigned cursor_col_now = 0;
   logic [7:0]  attr_now = tccs_pkg::ATTR_RESET;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Set at each rising edge when the request word in flight was taken, so the
   // driver at the following falling edge knows it may move on.
   logic        req_taken = 1'b0;

   // Pacing state of the sender (bursts and gaps) and of the receiver (stalls).
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned stall_tick = 0;

   always #5 clock = ~clock;

   text_console_cursor_scroll_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      foreach (screen_image[i]) screen_image[i] = tccs_pkg::BLANK_CELL;
   end

   // Moves the cursor down one row. Below the last row the whole screen moves
   // up by one row, the bottom row is filled with blanks in the current
   // attribute and the cursor stays on the last row. Returns 1 on a scroll.
   function automatic logic line_feed();
      cursor_row_now++;
      if (cursor_row_now >= ROWS) begin
         for (int unsigned i = 0; i < CELL_COUNT - COLS; i++) begin
            screen_image[i] = screen_image[i + COLS];
         end
         for (int unsigned i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
            screen_image[i] = {attr_now, tccs_pkg::BLANK_CHAR};
         end
         cursor_row_now = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one command to our image of the console and works out the result
   // word that the block must return for it.
   task automatic run_console_command(input console_cmd_type cmd,
                                      output tccs_pkg::rsp_type reply);
      logic [15:0] cell_word;
      logic        wrote;
      logic        scrolled;
      cell_word = '0;
      wrote = 1'b0;
      scrolled = 1'b0;
      case (cmd.op)
         tccs_pkg::OP_PUT: begin
            if (cmd.ch == tccs_pkg::CHAR_LF) begin
               cursor_col_now = 0;
               scrolled = line_feed();
            end else if (cmd.ch == tccs_pkg::CHAR_CR) begin
               cursor_col_now = 0;
            end else if (cmd.ch == tccs_pkg::CHAR_TAB) begin
               // Tab stops sit on multiples of eight; running off the right
               // edge behaves like a newline.
               cursor_col_now = (cursor_col_now + tccs_pkg::TAB_STEP)
                                & ~(tccs_pkg::TAB_STEP - 1);
               if (cursor_col_now >= COLS) begin
                  cursor_col_now = 0;
                  scrolled = line_feed();
               end
            end else begin
               cell_word = {attr_now, cmd.ch};
               screen_image[cursor_row_now * COLS + cursor_col_now] = cell_word;
               wrote = 1'b1;
               cursor_col_now++;
               if (cursor_col_now >= COLS) begin
                  cursor_col_now = 0;
                  scrolled = line_feed();
               end
            end
         end
         tccs_pkg::OP_CLEAR: begin
            foreach (screen_image[i]) screen_image[i] = tccs_pkg::BLANK_CELL;
            cursor_row_now = 0;
            cursor_col_now = 0;
         end
         tccs_pkg::OP_READ: begin
            // Reads beyond the end of the screen return zero.
            if (cmd.idx < CELL_COUNT) cell_word = screen_image[cmd.idx];
         end
         default: begin
            // The unused opcode only reports the cursor.
         end
      endcase
      reply = '0;
      reply.cursor_row = cursor_row_now[4:0];
      reply.cursor_col = cursor_col_now[6:0];
      reply.cell_value = cell_word;
      reply.wrote_cell = wrote;
      reply.scrolled = scrolled;
   endtask

   // Request driver. A word stays on the bus until it has been taken; after
   // that the next one goes out unless the sender is in a gap between bursts.
   always @(negedge clock) begin
      console_cmd_type cmd;
      logic            next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (command_backlog.size() > 0) begin
            cmd = command_backlog.pop_front();
            req_tdata <= {5'd0, cmd.idx, cmd.ch};
            req_tuser <= cmd.op;
            next_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // A new burst starts; one in four follows its predecessor
               // without any gap at all.
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Result receiver. It switches at random intervals between always ready,
   // random stalls, and a sparse fixed pattern that holds results long.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ((stall_tick % 9) < 2);
      endcase
   end

   // Monitor. Everything is sampled at the rising edge: attribute writes and
   // accepted commands update our image, and every accepted result word is
   // checked against the oldest owed one.
   always @(posedge clock) begin
      console_cmd_type   cmd;
      tccs_pkg::rsp_type reply;
      tccs_pkg::rsp_type want;
      tccs_pkg::rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) attr_now = csr_data;
         if (req_tvalid && req_tready) begin
            cmd.op = tccs_pkg::op_type'(req_tuser);
            cmd.ch = req_tdata[7:0];
            cmd.idx = req_tdata[18:8];
            run_console_command(cmd, reply);
            owed_replies.push_back(reply);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = tccs_pkg::rsp_type'(rsp_tdata);
            if (owed_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result word %h at cycle %0d", rsp_tdata, cycle_count);
               end
            end else begin
               want = owed_replies.pop_front();
               if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
                   got.cell_value !== want.cell_value || got.wrote_cell !== want.wrote_cell ||
                   got.scrolled !== want.scrolled) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"mismatch at cycle %0d: row %0d/%0d col %0d/%0d cell %h/%h",
                               " wrote %b/%b scrolled %b/%b (expected/actual)"},
                              cycle_count, want.cursor_row, got.cursor_row,
                              want.cursor_col, got.cursor_col, want.cell_value, got.cell_value,
                              want.wrote_cell, got.wrote_cell, want.scrolled, got.scrolled);
                  end
               end
            end
         end
      end
      req_taken <= req_tvalid && req_tready;
   end

   // Cycle counter with the run limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic queue_command(input tccs_pkg::op_type op, input logic [7:0] ch,
                                input logic [10:0] idx);
      console_cmd_type cmd;
      cmd.op = op;
      cmd.ch = ch;
      cmd.idx = idx;
      command_backlog.push_back(cmd);
   endtask

   // Waits until every command has been driven and every owed word has come
   // back, then lets the block settle before it returns.
   task automatic wait_until_drained();
      while (command_backlog.size() != 0 || req_tvalid || owed_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // The attribute is only written while the block is idle.
   task automatic write_attribute(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Fills the backlog with one phase of random traffic. Most of it is text:
   // lines of characters ended by newline or return, runs of newlines that push
   // the cursor to the bottom and scroll, and tabs. Reads sample the store,
   // leaning toward the bottom rows where scrolling moves cells around. Clears
   // are rare because a clear sweeps the whole screen.
   task automatic queue_random_phase(input int unsigned target);
      int unsigned queued;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  ch;
      logic [10:0] idx;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
            for (int unsigned i = 0; i < len; i++) begin
               ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
               queue_command(tccs_pkg::OP_PUT, ch, 11'($urandom));
            end
            queued += len;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_LF, 11'($urandom));
               queued++;
            end else if (pick < 8) begin
               queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_CR, 11'($urandom));
               queued++;
            end
         end else if (pick < 77) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) idx = 11'($urandom_range(CELL_COUNT, 2047));
            else if (pick < 10) idx = 11'($urandom_range(CELL_COUNT - 5 * COLS, CELL_COUNT - 1));
            else idx = 11'($urandom_range(0, CELL_COUNT - 1));
            queue_command(tccs_pkg::OP_READ, 8'($urandom), idx);
            queued++;
         end else if (pick < 88) begin
            len = $urandom_range(1, 30);
            for (int unsigned i = 0; i < len; i++) begin
               queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_LF, 11'($urandom));
            end
            queued += len;
         end else if (pick < 94) begin
            len = $urandom_range(1, 12);
            for (int unsigned i = 0; i < len; i++) begin
               queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_TAB, 11'($urandom));
            end
            queued += len;
         end else if (pick < 99) begin
            queue_command(tccs_pkg::OP_NONE, 8'($urandom), 11'($urandom));
            queued++;
         end else begin
            queue_command(tccs_pkg::OP_CLEAR, 8'($urandom), 11'($urandom));
            queued++;
         end
      end
   endtask

   initial begin
      logic [7:0] phase_attr[5];
      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = 8'($urandom);
      phase_attr[3] = 8'($urandom);
      phase_attr[4] = tccs_pkg::ATTR_RESET;

      // Synchronous reset, released at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, under the attribute the block comes out of reset with.
      // The store starts blank, so the first and last cells read as blanks and
      // a read past the end reads as zero.
      queue_command(tccs_pkg::OP_READ, 8'hFF, 11'd0);
      queue_command(tccs_pkg::OP_READ, 8'h00, 11'(CELL_COUNT - 1));
      queue_command(tccs_pkg::OP_READ, 8'h5A, 11'h7FF);
      queue_command(tccs_pkg::OP_NONE, 8'hFF, 11'h7FF);
      // Printable characters at both ends of the byte range.
      queue_command(tccs_pkg::OP_PUT, "A", 11'h000);
      queue_command(tccs_pkg::OP_PUT, 8'h00, 11'h7FF);
      queue_command(tccs_pkg::OP_PUT, 8'hFF, 11'h2AA);
      // Tab from mid-stop, return, newline.
      queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_TAB, 11'h555);
      queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_CR, 11'h000);
      queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_LF, 11'h000);
      // Ten tabs from column 0: the last one runs off the right edge and wraps.
      for (int i = 0; i < 10; i++) begin
         queue_command(tccs_pkg::OP_PUT, tccs_pkg::CHAR_TAB, 11'($urandom));
      end
      // The three characters written above.
      queue_command(tccs_pkg::OP_READ, 8'h00, 11'd0);
      queue_command(tccs_pkg::OP_READ, 8'h00, 11'd1);
      queue_command(tccs_pkg::OP_READ, 8'h00, 11'd2);
      // Clear blanks the store and homes the cursor.
      queue_command(tccs_pkg::OP_CLEAR, 8'hFF, 11'h7FF);
      queue_command(tccs_pkg::OP_READ, 8'h00, 11'd1);
      wait_until_drained();

      // Random phases, each under its own attribute, the extremes first.
      for (int p = 0; p < 5; p++) begin
         write_attribute(phase_attr[p]);
         queue_random_phase(PHASE_ITEMS);
         wait_until_drained();
      end

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
